@@ rtl/core/hysteresis_thermostat_with_dwell_defines.svh @@
// ----------------------------------------------------------------------------
// Thermostat assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_THERMOSTAT_WITH_DWELL_DEFINES_SVH
`define HYSTERESIS_THERMOSTAT_WITH_DWELL_DEFINES_SVH

// Same-cycle implication
`define HTD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/htd_pkg.sv @@
// ----------------------------------------------------------------------------
// htd_pkg
// Types and constants of the hysteresis thermostat with minimum dwell.
// ----------------------------------------------------------------------------
package htd_pkg;

   // Sample width; fixes the temperature field of the request
   localparam int SAMPLE_WIDTH = 16;

   // Compare width: holds the sample and setpoint +/- a 15-bit margin
   localparam int CMP_W = ((SAMPLE_WIDTH > 17) ? SAMPLE_WIDTH : 17) + 1;

   localparam int DWELL_W = 17;
   localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};

   // Configuration register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HYST_UP  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HYST_LO  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DWELL    = 4'd3;

   // Reset values of the registers
   localparam logic signed [15:0] SETPOINT_RST = 16'sd1600;
   localparam logic [14:0] HYST_UP_RST = 15'd50;
   localparam logic [14:0] HYST_LO_RST = 15'd50;
   localparam logic [15:0] DWELL_RST   = 16'd10;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      PH_STOPPED = 2'd0,
      PH_STARTED = 2'd1,
      PH_INIT    = 2'd2,
      PH_RUNNING = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]                     opcode;
      logic signed [SAMPLE_WIDTH-1:0] temperature;
   } req_type;

   typedef struct packed {
      logic       cooler_on;
      logic [1:0] run_state;
   } rsp_type;

endpackage

@@ rtl/core/hysteresis_thermostat_with_dwell.sv @@
// ----------------------------------------------------------------------------
// hysteresis_thermostat_with_dwell
// Bang-bang cooler control with hysteresis and a minimum dwell between switches.
// ----------------------------------------------------------------------------
// Each accepted command (tick with sample, start, stop) is applied to the run
// state, cooler bit and 17-bit dwell counter in the cycle it is accepted, and
// its one result is written to the output or, if held, the skid register. One
// item is taken every clock; the only limit is the two-entry output buffer
// (output register plus skid register): req_stall rises only while both hold
// results that the consumer has not taken. Configuration is written through
// the csr_ port, always ready; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module hysteresis_thermostat_with_dwell
   import htd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // command channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata
);

`include "hysteresis_thermostat_with_dwell_defines.svh"

   // Configuration registers
   logic signed [15:0] setpoint_ff;
   logic [14:0]        hyst_up_ff;
   logic [14:0]        hyst_lo_ff;
   logic [15:0]        dwell_ticks_ff;

   // Control state
   phase_type          phase_ff, phase_in;
   logic               cooler_ff, cooler_in;
   logic [DWELL_W-1:0] dwell_ff, dwell_in;

   // Output buffer
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_data_ff, skid_data_ff;

   logic    req_xfer, rsp_xfer;
   rsp_type result;

   // Compare operands
   logic signed [CMP_W-1:0] temp_ext, hi_lim, lo_lim;
   logic [DWELL_W-1:0]      dwell_inc;
   logic                    dwell_met;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !skid_valid_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff    <= SETPOINT_RST;
         hyst_up_ff     <= HYST_UP_RST;
         hyst_lo_ff     <= HYST_LO_RST;
         dwell_ticks_ff <= DWELL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SETPOINT: setpoint_ff    <= $signed(csr_wdata);
            REG_HYST_UP:  hyst_up_ff     <= csr_wdata[14:0];
            REG_HYST_LO:  hyst_lo_ff     <= csr_wdata[14:0];
            REG_DWELL:    dwell_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Switching thresholds, widened so they never overflow
   always_comb begin
      temp_ext = CMP_W'(req_data.temperature);
      hi_lim   = CMP_W'(setpoint_ff) + $signed({{(CMP_W-15){1'b0}}, hyst_up_ff});
      lo_lim   = CMP_W'(setpoint_ff) - $signed({{(CMP_W-15){1'b0}}, hyst_lo_ff});
   end

   // Saturating dwell advance and limit check
   assign dwell_inc = (dwell_ff == DWELL_MAX) ? DWELL_MAX : dwell_ff + 1'b1;
   assign dwell_met = dwell_inc >= {1'b0, dwell_ticks_ff};

   // Next state for the accepted command
   always_comb begin
      phase_in  = phase_ff;
      cooler_in = cooler_ff;
      dwell_in  = dwell_ff;
      unique case (req_data.opcode)
         OP_START: begin
            phase_in = PH_STARTED;
            dwell_in = DWELL_MAX;
         end
         OP_STOP: begin
            phase_in = PH_STOPPED;
         end
         OP_TICK: begin
            unique case (phase_ff)
               PH_STARTED: phase_in = PH_INIT;
               PH_INIT:    phase_in = PH_RUNNING;
               PH_RUNNING: begin
                  dwell_in = dwell_inc;
                  if (dwell_met) begin
                     // either switch may apply, or neither
                     if (temp_ext > hi_lim && !cooler_ff) begin
                        cooler_in = 1'b1;
                        dwell_in  = '0;
                     end else if (temp_ext < lo_lim && cooler_ff) begin
                        cooler_in = 1'b0;
                        dwell_in  = '0;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      result.cooler_on = cooler_in;
      result.run_state = phase_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STOPPED;
         cooler_ff <= 1'b0;
         dwell_ff  <= '0;
      end else if (req_xfer) begin
         phase_ff  <= phase_in;
         cooler_ff <= cooler_in;
         dwell_ff  <= dwell_in;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_xfer) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_xfer) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_xfer) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (req_xfer) begin
         if (!rsp_valid_ff || rsp_xfer) begin
            rsp_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   // Checks
   `HTD_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, rsp_valid_ff, "skid full with output empty")
   `HTD_ASSERT_NEXT(a_start_arms, req_xfer && req_data.opcode == OP_START, phase_ff == PH_STARTED && dwell_ff == DWELL_MAX, "start did not arm dwell")
   `HTD_ASSERT_NOW(a_switch_clears, cooler_ff != $past(cooler_ff), dwell_ff == '0, "switch without dwell clear")
   `HTD_ASSERT_NEXT(a_stop_keeps_out, req_xfer && req_data.opcode == OP_STOP, cooler_ff == $past(cooler_ff), "stop changed cooler")

endmodule
